// ----- sv/ssrp_pkg.sv -----
// ----------------------------------------------------------------------------
// Subset-sum reachable positions: shared package
// Field widths, command and register codes, walk control types and the
// bit-search helpers used by the bitmap datapath.
// ----------------------------------------------------------------------------
package ssrp_pkg;

   // Widths of the request, result and register fields.
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned SIZE_W     = 10;
   localparam int unsigned POS_W      = 8;
   localparam int unsigned CHUNK_W    = 4;
   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned BIT_W      = 6;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 10;

   // Request command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_STRIP_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXCLUDED_ITEM = 2'd2;

   // What the walk does to each bitmap word.
   typedef enum logic [1:0] {
      MODE_KEEP  = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_ADD   = 2'd2
   } mode_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_WALK  = 2'd1,
      ST_DRAIN = 2'd2,
      ST_DONE  = 2'd3
   } state_type;

   // Walk control from the sequencer to the datapath.
   typedef struct packed {
      logic               start;   // a request was accepted, reset the result capture
      logic               issue;   // read the word at idx this cycle
      logic [CHUNK_W-1:0] idx;     // word being issued
      mode_type           mode;
      logic [CHUNK_W-1:0] ws;      // item size in whole words
      logic [BIT_W-1:0]   bs;      // item size, bit within the word
      logic [CHUNK_W-1:0] chunk;   // word to report
   } walk_ctl_type;

   // Ones in bit positions 0 up to and including b.
   function automatic logic [WORD_BITS-1:0] low_mask(input logic [BIT_W-1:0] b);
      low_mask = {WORD_BITS{1'b1}} >> (6'd63 - b);
   endfunction

   // Position of the highest set bit, found by halving the window.
   function automatic logic [BIT_W-1:0] lead_one(input logic [WORD_BITS-1:0] v);
      logic [WORD_BITS-1:0] rest;
      logic [BIT_W-1:0]     pos;
      rest = v;
      pos  = '0;
      for (int k = BIT_W - 1; k >= 0; k--) begin
         if ((rest >> (1 << k)) != '0) begin
            pos[k] = 1'b1;
            rest   = rest >> (1 << k);
         end
      end
      lead_one = pos;
   endfunction

endpackage

// ----- sv/ssrp_ram.sv -----
// ----------------------------------------------------------------------------
// Subset-sum reachable positions: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ssrp_ram #(
   parameter int unsigned WIDTH  = 64,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   output logic [WIDTH-1:0]  rd_a_data,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [WIDTH-1:0]  rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Storage and registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ----- sv/ssrp_datapath.sv -----
// ----------------------------------------------------------------------------
// Subset-sum reachable positions: bitmap datapath
// Walks the bitmap words from high to low through the RAM, writes back the
// shifted-and-ORed or cleared words, and captures the reported chunk and the
// best reachable sum from the new value of each word, cut at the limit.
// ----------------------------------------------------------------------------
module ssrp_datapath #(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ssrp_pkg::walk_ctl_type            ctl,
   input  logic [ssrp_pkg::SIZE_W-1:0]       eff_limit,
   output logic                              last,
   output logic [ssrp_pkg::WORD_BITS-1:0]    chunk_word,
   output logic [ssrp_pkg::SIZE_W-1:0]       best
);

   logic [ssrp_pkg::CHUNK_W-1:0]   src_diff;
   logic                           src_ok;
   logic                           wr_en;
   logic [ssrp_pkg::WORD_BITS-1:0] rd_a_data;
   logic [ssrp_pkg::WORD_BITS-1:0] rd_b_data;

   logic                           p1_valid_ff;
   logic [ssrp_pkg::CHUNK_W-1:0]   p1_idx_ff;
   logic                           p1_ok_ff;

   logic                           p2_valid_ff;
   logic [ssrp_pkg::CHUNK_W-1:0]   p2_idx_ff;
   logic [ssrp_pkg::WORD_BITS-1:0] p2_old_ff;
   logic [ssrp_pkg::WORD_BITS-1:0] p2_src_ff;

   logic                           p3_valid_ff;
   logic [ssrp_pkg::CHUNK_W-1:0]   p3_idx_ff;
   logic [ssrp_pkg::WORD_BITS-1:0] p3_word_ff;

   logic [ssrp_pkg::WORD_BITS-1:0] lo_word;
   logic [ssrp_pkg::WORD_BITS-1:0] spill;
   logic [ssrp_pkg::WORD_BITS-1:0] new_word;
   logic [ssrp_pkg::WORD_BITS-1:0] masked;

   logic [ssrp_pkg::WORD_BITS-1:0] chunk_word_ff;
   logic [ssrp_pkg::WORD_BITS-1:0] chunk_word_in;
   logic [ssrp_pkg::SIZE_W-1:0]    best_ff;
   logic [ssrp_pkg::SIZE_W-1:0]    best_in;
   logic                           found_ff;
   logic                           found_in;

   logic [ssrp_pkg::CHUNK_W-1:0]   lim_word;
   logic [ssrp_pkg::BIT_W-1:0]     lim_bit;

   assign lim_word = eff_limit[ssrp_pkg::SIZE_W-1:ssrp_pkg::BIT_W];
   assign lim_bit  = eff_limit[ssrp_pkg::BIT_W-1:0];

   // Issue: the word itself on port A, its source word on port B. A source
   // below word zero contributes nothing.
   assign src_diff = ctl.idx - ctl.ws;
   assign src_ok   = (ctl.idx >= ctl.ws) && (ctl.mode == ssrp_pkg::MODE_ADD);

   ssrp_ram #(
      .WIDTH  (ssrp_pkg::WORD_BITS),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) map_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (p2_idx_ff[ADDR_W-1:0]),
      .wr_data   (new_word),
      .rd_a_addr (ctl.idx[ADDR_W-1:0]),
      .rd_a_data (rd_a_data),
      .rd_b_addr (src_diff[ADDR_W-1:0]),
      .rd_b_data (rd_b_data)
   );

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= ctl.issue;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   // Pipeline payload: read data is held one stage so that the next lower
   // source word, read in the following cycle, can supply the spill bits.
   always_ff @(posedge clock) begin
      p1_idx_ff  <= ctl.idx;
      p1_ok_ff   <= src_ok;
      p2_idx_ff  <= p1_idx_ff;
      p2_old_ff  <= rd_a_data;
      p2_src_ff  <= p1_ok_ff ? rd_b_data : '0;
      p3_idx_ff  <= p2_idx_ff;
      p3_word_ff <= new_word;
   end

   // Write-back word. The word in stage one is always the next lower one,
   // so its source read holds the bits that spill into this word.
   always_comb begin
      lo_word = (p1_valid_ff && p1_ok_ff) ? rd_b_data : '0;
      if (ctl.bs == '0) begin
         spill = '0;
      end else begin
         spill = lo_word >> (7'd64 - {1'b0, ctl.bs});
      end
      case (ctl.mode)
         ssrp_pkg::MODE_CLEAR: begin
            new_word = (p2_idx_ff == '0) ? {{(ssrp_pkg::WORD_BITS-1){1'b0}}, 1'b1} : '0;
         end
         ssrp_pkg::MODE_ADD: begin
            new_word = p2_old_ff | (p2_src_ff << ctl.bs) | spill;
         end
         default: begin
            new_word = p2_old_ff;
         end
      endcase
   end

   assign wr_en = p2_valid_ff && (ctl.mode != ssrp_pkg::MODE_KEEP);

   // Cut the written word at the limit.
   always_comb begin
      if (p3_idx_ff > lim_word) begin
         masked = '0;
      end else if (p3_idx_ff == lim_word) begin
         masked = p3_word_ff & ssrp_pkg::low_mask(lim_bit);
      end else begin
         masked = p3_word_ff;
      end
   end

   // Result capture: the reported chunk, and the first set bit met from
   // the top, which is the best sum.
   always_comb begin
      chunk_word_in = chunk_word_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      if (ctl.start) begin
         chunk_word_in = '0;
         best_in       = '0;
         found_in      = 1'b0;
      end else if (p3_valid_ff) begin
         if (p3_idx_ff == ctl.chunk) begin
            chunk_word_in = masked;
         end
         if (!found_ff && (masked != '0)) begin
            best_in  = {p3_idx_ff, ssrp_pkg::lead_one(masked)};
            found_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      chunk_word_ff <= chunk_word_in;
      best_ff       <= best_in;
   end

   assign last       = p3_valid_ff && (p3_idx_ff == '0);
   assign chunk_word = chunk_word_ff;
   assign best       = best_ff;

endmodule

// ----- sv/ssrp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Subset-sum reachable positions: request sequencer
// Decodes a request, steps the word counter over the bitmap from the top
// word down, waits for the pipeline to drain and hands the result over.
// After reset it runs one clearing walk without a result.
// ----------------------------------------------------------------------------
module ssrp_ctrl #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ssrp_pkg::CMD_W-1:0]        req_command,
   input  logic [ssrp_pkg::SIZE_W-1:0]       req_item_width,
   input  logic [ssrp_pkg::SIZE_W-1:0]       req_item_height,
   input  logic [ssrp_pkg::POS_W-1:0]        req_item_position,
   input  logic [ssrp_pkg::CHUNK_W-1:0]      req_chunk_index,
   input  logic                              use_width,
   input  logic [ssrp_pkg::POS_W-1:0]        excluded_item,
   input  logic                              last,
   input  logic                              rsp_free,
   output logic                              rsp_load,
   output logic                              skipped,
   output ssrp_pkg::walk_ctl_type            ctl
);

   localparam logic [ssrp_pkg::CHUNK_W-1:0] TOP_WORD = ssrp_pkg::CHUNK_W'(DEPTH - 1);

   ssrp_pkg::state_type            state_ff;
   ssrp_pkg::state_type            state_in;
   logic [ssrp_pkg::CHUNK_W-1:0]   idx_ff;
   logic [ssrp_pkg::CHUNK_W-1:0]   idx_in;
   ssrp_pkg::mode_type             mode_ff;
   ssrp_pkg::mode_type             mode_in;
   logic                           report_ff;
   logic                           report_in;
   logic [ssrp_pkg::CHUNK_W-1:0]   ws_ff;
   logic [ssrp_pkg::CHUNK_W-1:0]   ws_in;
   logic [ssrp_pkg::BIT_W-1:0]     bs_ff;
   logic [ssrp_pkg::BIT_W-1:0]     bs_in;
   logic [ssrp_pkg::CHUNK_W-1:0]   chunk_ff;
   logic [ssrp_pkg::CHUNK_W-1:0]   chunk_in;
   logic                           skipped_ff;
   logic                           skipped_in;

   logic                           accept;
   logic                           issue;
   logic [ssrp_pkg::SIZE_W-1:0]    size;
   logic                           is_excluded;

   assign accept      = req_valid && req_ready;
   assign size        = use_width ? req_item_width : req_item_height;
   assign is_excluded = (req_item_position == excluded_item);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssrp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ssrp_pkg::ST_WALK;
            end
         end
         ssrp_pkg::ST_WALK: begin
            if (idx_ff == '0) begin
               state_in = ssrp_pkg::ST_DRAIN;
            end
         end
         ssrp_pkg::ST_DRAIN: begin
            if (last) begin
               state_in = ssrp_pkg::ST_DONE;
            end
         end
         ssrp_pkg::ST_DONE: begin
            if (!report_ff || rsp_free) begin
               state_in = ssrp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssrp_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      issue     = 1'b0;
      case (state_ff)
         ssrp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         ssrp_pkg::ST_WALK: begin
            issue = 1'b1;
         end
         ssrp_pkg::ST_DONE: begin
            rsp_load = report_ff && rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Request decode and word counter.
   always_comb begin
      idx_in     = idx_ff;
      mode_in    = mode_ff;
      report_in  = report_ff;
      ws_in      = ws_ff;
      bs_in      = bs_ff;
      chunk_in   = chunk_ff;
      skipped_in = skipped_ff;
      if (accept) begin
         idx_in     = TOP_WORD;
         report_in  = 1'b1;
         ws_in      = size[ssrp_pkg::SIZE_W-1:ssrp_pkg::BIT_W];
         bs_in      = size[ssrp_pkg::BIT_W-1:0];
         chunk_in   = req_chunk_index;
         skipped_in = 1'b0;
         case (req_command)
            ssrp_pkg::CMD_CLEAR: begin
               mode_in = ssrp_pkg::MODE_CLEAR;
            end
            ssrp_pkg::CMD_ADD: begin
               if (is_excluded) begin
                  mode_in    = ssrp_pkg::MODE_KEEP;
                  skipped_in = 1'b1;
               end else begin
                  mode_in = ssrp_pkg::MODE_ADD;
               end
            end
            default: begin
               mode_in = ssrp_pkg::MODE_KEEP;
            end
         endcase
      end else if ((state_ff == ssrp_pkg::ST_WALK) && (idx_ff != '0)) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   // Control registers; reset starts the clearing walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ssrp_pkg::ST_WALK;
         idx_ff    <= TOP_WORD;
         mode_ff   <= ssrp_pkg::MODE_CLEAR;
         report_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         mode_ff   <= mode_in;
         report_ff <= report_in;
      end
   end

   always_ff @(posedge clock) begin
      ws_ff      <= ws_in;
      bs_ff      <= bs_in;
      chunk_ff   <= chunk_in;
      skipped_ff <= skipped_in;
   end

   assign ctl.start = accept;
   assign ctl.issue = issue;
   assign ctl.idx   = idx_ff;
   assign ctl.mode  = mode_ff;
   assign ctl.ws    = ws_ff;
   assign ctl.bs    = bs_ff;
   assign ctl.chunk = chunk_ff;
   assign skipped   = skipped_ff;

endmodule

// ----- sv/subset_sum_reachable_positions_unit.sv -----
// ----------------------------------------------------------------------------
// Subset-sum reachable positions unit
// Reachable-sum bitmap for 0/1 subset sum with clear, add and read requests.
// ----------------------------------------------------------------------------
// The unit keeps one bit per position in a RAM of 64-bit words and answers
// each request with one result: a 64-position chunk of the bitmap cut at the
// strip limit, the largest reachable sum not above the limit, and whether an
// add was skipped as the excluded item. Every request walks the stored words
// once from the top word down through the RAM's two read ports and one write
// port, and the next request is taken only once that walk has drained.
// DEPTH, the number of words, is MAX_POSITIONS / 64 capped at 16. A waiting
// result does not hold up the next request until that request's own result
// is ready. After reset the unit clears the bitmap in one walk with req_ready
// low; configuration writes are taken at any time. MAX_POSITIONS must be a
// multiple of 64.
// ----------------------------------------------------------------------------
module subset_sum_reachable_positions_unit #(
   parameter int unsigned MAX_POSITIONS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ssrp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssrp_pkg::CSR_DATA_W-1:0]   csr_data,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ssrp_pkg::CMD_W-1:0]        req_command,
   input  logic [ssrp_pkg::SIZE_W-1:0]       req_item_width,
   input  logic [ssrp_pkg::SIZE_W-1:0]       req_item_height,
   input  logic [ssrp_pkg::POS_W-1:0]        req_item_position,
   input  logic [ssrp_pkg::CHUNK_W-1:0]      req_chunk_index,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ssrp_pkg::WORD_BITS-1:0]    rsp_reachable_chunk,
   output logic [ssrp_pkg::SIZE_W-1:0]       rsp_best_sum,
   output logic                              rsp_item_skipped
);

   localparam int unsigned MAP_WORDS  = MAX_POSITIONS / ssrp_pkg::WORD_BITS;
   localparam int unsigned WORD_LIMIT = 1 << ssrp_pkg::CHUNK_W;
   localparam int unsigned DEPTH      = (MAP_WORDS < WORD_LIMIT) ? MAP_WORDS : WORD_LIMIT;
   localparam int unsigned ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned FIELD_MAX  = (1 << ssrp_pkg::SIZE_W) - 1;
   localparam int unsigned LIM_CAP    =
      (MAX_POSITIONS - 1 < FIELD_MAX) ? MAX_POSITIONS - 1 : FIELD_MAX;

   logic [ssrp_pkg::SIZE_W-1:0]    strip_limit_ff;
   logic [ssrp_pkg::SIZE_W-1:0]    strip_limit_in;
   logic                           use_width_ff;
   logic                           use_width_in;
   logic [ssrp_pkg::POS_W-1:0]     excluded_item_ff;
   logic [ssrp_pkg::POS_W-1:0]     excluded_item_in;

   logic [ssrp_pkg::SIZE_W-1:0]    eff_limit;
   ssrp_pkg::walk_ctl_type         ctl;
   logic                           last;
   logic                           rsp_free;
   logic                           rsp_load;
   logic                           skipped;
   logic [ssrp_pkg::WORD_BITS-1:0] chunk_word;
   logic [ssrp_pkg::SIZE_W-1:0]    best;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [ssrp_pkg::WORD_BITS-1:0] rsp_chunk_ff;
   logic [ssrp_pkg::SIZE_W-1:0]    rsp_best_ff;
   logic                           rsp_skipped_ff;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      strip_limit_in   = strip_limit_ff;
      use_width_in     = use_width_ff;
      excluded_item_in = excluded_item_ff;
      if (csr_valid) begin
         case (csr_index)
            ssrp_pkg::CSR_STRIP_LIMIT: begin
               strip_limit_in = csr_data;
            end
            ssrp_pkg::CSR_USE_WIDTH: begin
               use_width_in = csr_data[0];
            end
            ssrp_pkg::CSR_EXCLUDED_ITEM: begin
               excluded_item_in = csr_data[ssrp_pkg::POS_W-1:0];
            end
            default: begin
               strip_limit_in = strip_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_limit_ff   <= ssrp_pkg::SIZE_W'(FIELD_MAX);
         use_width_ff     <= 1'b1;
         excluded_item_ff <= '0;
      end else begin
         strip_limit_ff   <= strip_limit_in;
         use_width_ff     <= use_width_in;
         excluded_item_ff <= excluded_item_in;
      end
   end

   // The limit never reaches past the last stored position.
   assign eff_limit = (strip_limit_ff < ssrp_pkg::SIZE_W'(LIM_CAP)) ?
                      strip_limit_ff : ssrp_pkg::SIZE_W'(LIM_CAP);

   ssrp_ctrl #(
      .DEPTH (DEPTH)
   ) ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_item_width    (req_item_width),
      .req_item_height   (req_item_height),
      .req_item_position (req_item_position),
      .req_chunk_index   (req_chunk_index),
      .use_width         (use_width_ff),
      .excluded_item     (excluded_item_ff),
      .last              (last),
      .rsp_free          (rsp_free),
      .rsp_load          (rsp_load),
      .skipped           (skipped),
      .ctl               (ctl)
   );

   ssrp_datapath #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .eff_limit  (eff_limit),
      .last       (last),
      .chunk_word (chunk_word),
      .best       (best)
   );

   // Result register.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_chunk_ff   <= chunk_word;
         rsp_best_ff    <= best;
         rsp_skipped_ff <= skipped;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_reachable_chunk = rsp_chunk_ff;
   assign rsp_best_sum        = rsp_best_ff;
   assign rsp_item_skipped    = rsp_skipped_ff;

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for the subset-sum reachable positions unit
// Drives clear, add and read requests, first from a short directed table and
// then as random clear-then-add episodes mixed with noise. Every result is
// checked against typed-in values or a bit-vector model of the reachable-sum map,
// under several register settings and patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAP_BITS    = 1024;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned PHASE_ITEMS = 305;
   localparam int unsigned SETTLE      = 30;

   // Command code with no operation; the unit answers it as a plain read.
   localparam logic [ssrp_pkg::CMD_W-1:0]     CMD_SPARE = 2'd3;
   // Register index with no register behind it.
   localparam logic [ssrp_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [ssrp_pkg::WORD_BITS-1:0] chunk;
      logic [ssrp_pkg::SIZE_W-1:0]    best;
      logic                           skipped;
   } result_type;

   typedef struct {
      logic [ssrp_pkg::CMD_W-1:0]     cmd;
      logic [ssrp_pkg::SIZE_W-1:0]    wid;
      logic [ssrp_pkg::SIZE_W-1:0]    hgt;
      logic [ssrp_pkg::POS_W-1:0]     pos;
      logic [ssrp_pkg::CHUNK_W-1:0]   chunk;
      bit                             pinned;
      result_type                     want;
   } dir_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [ssrp_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [ssrp_pkg::CSR_DATA_W-1:0]   csr_data = '0;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [ssrp_pkg::CMD_W-1:0]        req_command = '0;
   logic [ssrp_pkg::SIZE_W-1:0]       req_item_width = '0;
   logic [ssrp_pkg::SIZE_W-1:0]       req_item_height = '0;
   logic [ssrp_pkg::POS_W-1:0]        req_item_position = '0;
   logic [ssrp_pkg::CHUNK_W-1:0]      req_chunk_index = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [ssrp_pkg::WORD_BITS-1:0]    rsp_reachable_chunk;
   logic [ssrp_pkg::SIZE_W-1:0]       rsp_best_sum;
   logic                              rsp_item_skipped;

   // Model state: one bit per position, plus the register copies.
   logic [MAP_BITS-1:0]               reach_bits = 1;
   logic [ssrp_pkg::SIZE_W-1:0]       limit_cfg = 10'd1023;
   logic                              use_width_cfg = 1'b1;
   logic [ssrp_pkg::POS_W-1:0]        excluded_cfg = '0;

   result_type                        pending_results[$];
   dir_row_type                       dir_rows[$];
   result_type                        want_r;
   result_type                        got_r;

   int                                send_gap_pct = 0;
   int                                stall_pct = 0;
   logic                              hold_off = 1'b0;
   int unsigned                       cycle_cnt = 0;
   int                                n_accepted = 0;
   int                                n_results = 0;
   int                                n_bad = 0;
   int                                n_skipped = 0;
   int                                n_settings = 1;
   int                                n_cmd[4] = '{0, 0, 0, 0};

   subset_sum_reachable_positions_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_item_width      (req_item_width),
      .req_item_height     (req_item_height),
      .req_item_position   (req_item_position),
      .req_chunk_index     (req_chunk_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_reachable_chunk (rsp_reachable_chunk),
      .rsp_best_sum        (rsp_best_sum),
      .rsp_item_skipped    (rsp_item_skipped)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Random field values at the request widths.
   function automatic logic [ssrp_pkg::SIZE_W-1:0] rand10();
      return ssrp_pkg::SIZE_W'($urandom_range(1023));
   endfunction

   function automatic logic [ssrp_pkg::POS_W-1:0] rand8();
      return ssrp_pkg::POS_W'($urandom_range(255));
   endfunction

   function automatic logic [ssrp_pkg::CHUNK_W-1:0] rand4();
      return ssrp_pkg::CHUNK_W'($urandom_range(15));
   endfunction

   // Mostly small sizes so that sums stay spread out, with some large ones.
   function automatic logic [ssrp_pkg::SIZE_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return ssrp_pkg::SIZE_W'($urandom_range(64, 1));
      if (roll < 80) return ssrp_pkg::SIZE_W'($urandom_range(300, 65));
      if (roll < 95) return rand10();
      return '0;
   endfunction

   // The excluded position is hit often enough to see skips.
   function automatic logic [ssrp_pkg::POS_W-1:0] pick_position();
      if ($urandom_range(99) < 25) return excluded_cfg;
      return rand8();
   endfunction

   // Low chunks hold most of the interesting bits.
   function automatic logic [ssrp_pkg::CHUNK_W-1:0] pick_chunk();
      if ($urandom_range(99) < 60) return ssrp_pkg::CHUNK_W'($urandom_range(3));
      return rand4();
   endfunction

   // Apply one request to the reachable-sum map and work out its result.
   task automatic update_reach_map(input logic [ssrp_pkg::CMD_W-1:0] cmd,
                                   input logic [ssrp_pkg::SIZE_W-1:0] wid,
                                   input logic [ssrp_pkg::SIZE_W-1:0] hgt,
                                   input logic [ssrp_pkg::POS_W-1:0] pos,
                                   input logic [ssrp_pkg::CHUNK_W-1:0] chunk,
                                   output result_type res);
      logic [MAP_BITS-1:0]         visible;
      logic [ssrp_pkg::SIZE_W-1:0] size;
      int                          p;
      res  = '0;
      size = use_width_cfg ? wid : hgt;
      if (cmd == ssrp_pkg::CMD_CLEAR) begin
         reach_bits = 1;
      end else if (cmd == ssrp_pkg::CMD_ADD) begin
         if (pos == excluded_cfg) begin
            res.skipped = 1'b1;
         end else begin
            reach_bits = reach_bits | (reach_bits << size);
         end
      end
      // Only positions up to the strip limit are seen.
      visible   = reach_bits & ({MAP_BITS{1'b1}} >> (10'd1023 - limit_cfg));
      res.chunk = visible[chunk*64 +: 64];
      p = int'(limit_cfg);
      while (p > 0 && !visible[p]) p--;
      res.best = ssrp_pkg::SIZE_W'(p);
   endtask

   // Offer one request and book its expected result once it is taken.
   task automatic send_request(input logic [ssrp_pkg::CMD_W-1:0] cmd,
                               input logic [ssrp_pkg::SIZE_W-1:0] wid,
                               input logic [ssrp_pkg::SIZE_W-1:0] hgt,
                               input logic [ssrp_pkg::POS_W-1:0] pos,
                               input logic [ssrp_pkg::CHUNK_W-1:0] chunk,
                               input bit pinned = 1'b0,
                               input result_type pin_res = '0);
      result_type res;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_item_width    <= wid;
      req_item_height   <= hgt;
      req_item_position <= pos;
      req_chunk_index   <= chunk;
      do @(posedge clock); while (!req_ready);
      update_reach_map(cmd, wid, hgt, pos, chunk, res);
      if (res.skipped) n_skipped++;
      if (pinned) res = pin_res;
      pending_results = {pending_results, res};
      n_accepted++;
      n_cmd[cmd]++;
   endtask

   task automatic add_row(input logic [ssrp_pkg::CMD_W-1:0] cmd,
                          input logic [ssrp_pkg::SIZE_W-1:0] wid,
                          input logic [ssrp_pkg::SIZE_W-1:0] hgt,
                          input logic [ssrp_pkg::POS_W-1:0] pos,
                          input logic [ssrp_pkg::CHUNK_W-1:0] chunk,
                          input bit pinned = 1'b0,
                          input logic [ssrp_pkg::WORD_BITS-1:0] x_chunk = '0,
                          input logic [ssrp_pkg::SIZE_W-1:0] x_best = '0,
                          input logic x_skip = 1'b0);
      dir_row_type row;
      row.cmd    = cmd;
      row.wid    = wid;
      row.hgt    = hgt;
      row.pos    = pos;
      row.chunk  = chunk;
      row.pinned = pinned;
      row.want   = {x_chunk, x_best, x_skip};
      dir_rows   = {dir_rows, row};
   endtask

   // One register write; the caller lowers csr_valid after the batch.
   task automatic write_reg(input logic [ssrp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ssrp_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ssrp_pkg::CSR_STRIP_LIMIT:   limit_cfg = data;
         ssrp_pkg::CSR_USE_WIDTH:     use_width_cfg = data[0];
         ssrp_pkg::CSR_EXCLUDED_ITEM: excluded_cfg = data[ssrp_pkg::POS_W-1:0];
         default: ;
      endcase
   endtask

   // Write every register; unused upper data bits carry random values.
   task automatic program_regs(input logic [ssrp_pkg::SIZE_W-1:0] limit, input logic use_w,
                               input logic [ssrp_pkg::POS_W-1:0] excl);
      write_reg(ssrp_pkg::CSR_STRIP_LIMIT, limit);
      write_reg(ssrp_pkg::CSR_USE_WIDTH, {9'($urandom_range(511)), use_w});
      write_reg(ssrp_pkg::CSR_EXCLUDED_ITEM, {2'($urandom_range(3)), excl});
      write_reg(CSR_SPARE, rand10());
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // Stop offering, let every result come back, then let the unit settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Mostly clear-then-add episodes with reads mixed in; the rest is noise.
   task automatic run_subset_episodes(input int n_items);
      int                          sent;
      int                          steps;
      logic [ssrp_pkg::SIZE_W-1:0] sz;
      logic [ssrp_pkg::SIZE_W-1:0] other;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 80) begin
            send_request(ssrp_pkg::CMD_CLEAR, rand10(), rand10(), rand8(), rand4());
            sent++;
            steps = $urandom_range(12, 1);
            repeat (steps) begin
               if ($urandom_range(3) != 0) begin
                  sz    = pick_size();
                  other = rand10();
                  send_request(ssrp_pkg::CMD_ADD, use_width_cfg ? sz : other,
                               use_width_cfg ? other : sz, pick_position(), pick_chunk());
               end else begin
                  send_request(ssrp_pkg::CMD_READ, rand10(), rand10(), rand8(),
                               pick_chunk());
               end
               sent++;
            end
         end else begin
            send_request(ssrp_pkg::CMD_W'($urandom_range(3)), rand10(), rand10(), rand8(),
                         rand4());
            sent++;
         end
      end
   endtask

   // Receiver: random stalls, plus one long hold-off while it is armed.
   always @(posedge clock) begin
      rsp_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   // Long hold-off early in the random part, so the unit fills and stalls.
   initial begin
      wait (n_accepted >= 60);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Compare each returned result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         got_r = {rsp_reachable_chunk, rsp_best_sum, rsp_item_skipped};
         if (pending_results.size() == 0) begin
            n_bad++;
            if (n_bad <= 10)
               $display("result %0d arrived with nothing expected: chunk %h best %0d",
                        n_results, got_r.chunk, got_r.best);
         end else begin
            want_r = pending_results.pop_front();
            if (got_r !== want_r) begin
               n_bad++;
               if (n_bad <= 10) begin
                  $display("result %0d: expected chunk %h best %0d skipped %0b",
                           n_results, want_r.chunk, want_r.best, want_r.skipped);
                  $display("result %0d: got      chunk %h best %0d skipped %0b",
                           n_results, got_r.chunk, got_r.best, got_r.skipped);
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_cnt, pending_results.size());
         $display("tb: FAIL");
         $finish;
      end
   end

   // Main sequence: reset, directed table, then random phases.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Results that can be read off directly are typed in; others are predicted.
      add_row(ssrp_pkg::CMD_READ, 10'd0, 10'd0, 8'd0, 4'd0, 1'b1, 64'h1, 10'd0, 1'b0);
      add_row(ssrp_pkg::CMD_READ, 10'd0, 10'd0, 8'd0, 4'd15, 1'b1, 64'h0, 10'd0, 1'b0);
      add_row(ssrp_pkg::CMD_ADD, 10'd5, 10'd9, 8'd0, 4'd0, 1'b1, 64'h1, 10'd0, 1'b1);
      add_row(ssrp_pkg::CMD_ADD, 10'd0, 10'd7, 8'd1, 4'd0, 1'b1, 64'h1, 10'd0, 1'b0);
      add_row(ssrp_pkg::CMD_ADD, 10'd1023, 10'd0, 8'd2, 4'd15, 1'b1,
              64'h8000_0000_0000_0000, 10'd1023, 1'b0);
      add_row(ssrp_pkg::CMD_ADD, 10'd1, 10'd1023, 8'd255, 4'd0);
      add_row(ssrp_pkg::CMD_ADD, 10'd64, 10'd0, 8'd3, 4'd1);
      add_row(ssrp_pkg::CMD_ADD, 10'd63, 10'd1, 8'd4, 4'd0);
      add_row(ssrp_pkg::CMD_ADD, 10'd512, 10'd0, 8'd5, 4'd8);
      add_row(CMD_SPARE, 10'd1023, 10'd1023, 8'd255, 4'd7);
      add_row(ssrp_pkg::CMD_READ, 10'd0, 10'd0, 8'd0, 4'd1);
      add_row(ssrp_pkg::CMD_READ, 10'd0, 10'd0, 8'd0, 4'd8);
      add_row(ssrp_pkg::CMD_READ, 10'd1023, 10'd1023, 8'd255, 4'd15);
      add_row(ssrp_pkg::CMD_CLEAR, 10'd1023, 10'd1023, 8'd255, 4'd0, 1'b1, 64'h1, 10'd0,
              1'b0);
      add_row(ssrp_pkg::CMD_CLEAR, 10'd0, 10'd0, 8'd0, 4'd15, 1'b1, 64'h0, 10'd0, 1'b0);
      add_row(ssrp_pkg::CMD_ADD, 10'd1023, 10'd1023, 8'd0, 4'd15, 1'b1, 64'h0, 10'd0,
              1'b1);
      add_row(ssrp_pkg::CMD_ADD, 10'd1, 10'd0, 8'd1, 4'd0);
      add_row(ssrp_pkg::CMD_ADD, 10'd2, 10'd0, 8'd2, 4'd0);
      add_row(ssrp_pkg::CMD_ADD, 10'd4, 10'd0, 8'd3, 4'd0);
      add_row(ssrp_pkg::CMD_ADD, 10'd700, 10'd0, 8'd200, 4'd10);
      add_row(ssrp_pkg::CMD_READ, 10'd0, 10'd0, 8'd0, 4'd10);
      add_row(ssrp_pkg::CMD_ADD, 10'd1000, 10'd0, 8'd254, 4'd15);
      add_row(ssrp_pkg::CMD_READ, 10'd0, 10'd0, 8'd0, 4'd15);

      send_gap_pct = 8;
      stall_pct    = 65;
      foreach (dir_rows[i])
         send_request(dir_rows[i].cmd, dir_rows[i].wid, dir_rows[i].hgt, dir_rows[i].pos,
                      dir_rows[i].chunk, dir_rows[i].pinned, dir_rows[i].want);

      // Register settings change only when the unit is idle; the map is kept
      // across settings, so reads follow the new limit on old sums.
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         case (ph)
            0: program_regs(10'd1023, 1'b1, rand8());
            1: program_regs(10'd0, 1'b0, 8'd255);
            2: program_regs(10'd63, 1'b1, 8'd0);
            3: program_regs(rand10(), 1'b0, rand8());
            4: program_regs(10'd64, 1'b0, 8'd255);
            default: program_regs(rand10(), 1'b1, rand8());
         endcase
         if (ph < 2) begin
            send_gap_pct = 8;
            stall_pct    = 65;
         end else if (ph < 4) begin
            send_gap_pct = 65;
            stall_pct    = 8;
         end else begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end
         run_subset_episodes(PHASE_ITEMS);
      end

      wait_idle();
      $display("Sent %0d requests: %0d clear, %0d add (%0d skipped), %0d read, %0d spare code.",
               n_accepted, n_cmd[0], n_cmd[1], n_skipped, n_cmd[2], n_cmd[3]);
      $display("Checked %0d results under %0d register settings, %0d mismatches.",
               n_results, n_settings, n_bad);
      if (n_bad == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
